[hw/rtl/dotq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and codes for the deadline-ordered task queue.
// No dependencies; imported by the sequencer and the top level.
package dotq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int DEADLINE_BITS = 32;
    localparam int PAYLOAD_BITS  = 32;
    localparam int ADDR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_BITS    = DEADLINE_BITS + PAYLOAD_BITS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [DEADLINE_BITS-1:0] deadline;
        logic [PAYLOAD_BITS-1:0]  payload;
    } t_entry;

    typedef struct packed {
        logic                  head_valid;
        t_entry                head;
        t_status               status;
        logic [COUNT_BITS-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        t_entry               wr_data;
    } t_mem_req;

    // Ring-buffer address of logical position off counted from base.
    function automatic logic [ADDR_BITS-1:0] f_phys(input logic [ADDR_BITS-1:0] base,
                                                    input logic [COUNT_BITS-1:0] off);
        logic [COUNT_BITS:0] v_sum;
        v_sum = (COUNT_BITS+1)'(base) + (COUNT_BITS+1)'(off);
        if (v_sum >= (COUNT_BITS+1)'(QUEUE_DEPTH)) begin
            v_sum = v_sum - (COUNT_BITS+1)'(QUEUE_DEPTH);
        end
        return v_sum[ADDR_BITS-1:0];
    endfunction

endpackage

[hw/rtl/deadline_ordered_task_queue_unit.sv]
`timescale 1ns / 1ps
// Top level of the deadline-ordered task queue: entry RAM, sequencer, result register.
// Uses dotq_pkg, dotq_ram and dotq_seq.
// A refused request, an insert into an empty queue or a pop that empties the queue
//   finishes in the accept cycle; other pops finish in S_POP_RD (head refill read).
// An insert walks the RAM port from the tail one entry per cycle, shifting each stored
//   task with a later deadline up one slot, and finishes in S_INS_CMP or S_INS_PUT.
// Reset clears the count, ring pointer and control; RAM contents are not cleared.
module deadline_ordered_task_queue_unit import dotq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_op,
    input  logic [DEADLINE_BITS-1:0] i_task_deadline,
    input  logic [PAYLOAD_BITS-1:0]  i_task_payload,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_head_valid,
    output logic [DEADLINE_BITS-1:0] o_head_deadline,
    output logic [PAYLOAD_BITS-1:0]  o_head_payload,
    output logic [1:0]               o_status,
    output logic [COUNT_BITS-1:0]    o_entry_count
);

    t_mem_req              mem_req;
    logic [ENTRY_BITS-1:0] rd_word;
    t_entry                rd_data;
    logic                  done;
    t_result               result;
    logic                  out_busy;

    logic                  r_out_valid;
    t_result               r_out;

    assign rd_data  = rd_word;
    assign out_busy = r_out_valid && i_stall;

    dotq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_word)
    );

    dotq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_task_deadline (i_task_deadline),
        .i_task_payload  (i_task_payload),
        .i_out_busy      (out_busy),
        .o_mem           (mem_req),
        .i_rd_data       (rd_data),
        .o_done          (done),
        .o_result        (result)
    );

    // load on finish, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
            r_out       <= result;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_head_valid    = r_out.head_valid;
    assign o_head_deadline = r_out.head.deadline;
    assign o_head_payload  = r_out.head.payload;
    assign o_status        = r_out.status;
    assign o_entry_count   = r_out.entry_count;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !(r_out_valid && i_stall))
        else $error("result register overwritten while held");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("held result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && (result.status == ST_EMPTY)) |-> (!result.head_valid && result.entry_count == '0))
        else $error("refused pop reported a task");

endmodule

[hw/rtl/dotq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dotq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/dotq_seq.sv]
`timescale 1ns / 1ps
// Sequencer for the task queue: ring pointers, count, cached head entry and the
// read-compare-shift walk over the entry RAM. Uses dotq_pkg.
module dotq_seq import dotq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_op,
    input  logic [DEADLINE_BITS-1:0] i_task_deadline,
    input  logic [PAYLOAD_BITS-1:0]  i_task_payload,
    input  logic                     i_out_busy,
    output t_mem_req                 o_mem,
    input  t_entry                   i_rd_data,
    output logic                     o_done,
    output t_result                  o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_INS_CMP,
        S_INS_PUT
    } t_state;

    t_state                r_state,   n_state;
    logic [ADDR_BITS-1:0]  r_head,    n_head;
    logic [COUNT_BITS-1:0] r_count,   n_count;
    logic [COUNT_BITS-1:0] r_pos,     n_pos;
    t_entry                r_item,    n_item;
    t_entry                r_cache,   n_cache;

    logic   accept;
    t_entry new_item;

    assign o_stall  = (r_state != S_IDLE) || i_out_busy;
    assign accept   = i_valid && !o_stall;
    assign new_item = '{deadline: i_task_deadline, payload: i_task_payload};

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_pos    = r_pos;
        n_item   = r_item;
        n_cache  = r_cache;
        o_mem    = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: '0, wr_data: r_item};
        o_done   = 1'b0;
        o_result = '{head_valid: 1'b0, head: '0, status: ST_DONE, entry_count: r_count};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_INSERT) begin
                        if (r_count == COUNT_BITS'(QUEUE_DEPTH)) begin
                            o_done   = 1'b1;
                            o_result = '{head_valid: 1'b1, head: r_cache, status: ST_FULL,
                                         entry_count: r_count};
                        end else if (r_count == '0) begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_head;
                            o_mem.wr_data = new_item;
                            n_cache       = new_item;
                            n_count       = COUNT_BITS'(1);
                            o_done        = 1'b1;
                            o_result      = '{head_valid: 1'b1, head: new_item, status: ST_DONE,
                                              entry_count: COUNT_BITS'(1)};
                        end else begin
                            // start the walk at the tail
                            n_item        = new_item;
                            n_pos         = r_count;
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = f_phys(r_head, r_count - COUNT_BITS'(1));
                            n_state       = S_INS_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            o_done   = 1'b1;
                            o_result = '{head_valid: 1'b0, head: '0, status: ST_EMPTY,
                                         entry_count: '0};
                        end else begin
                            n_head  = f_phys(r_head, COUNT_BITS'(1));
                            n_count = r_count - COUNT_BITS'(1);
                            n_item  = r_cache;
                            if (r_count == COUNT_BITS'(1)) begin
                                o_done   = 1'b1;
                                o_result = '{head_valid: 1'b1, head: r_cache, status: ST_DONE,
                                             entry_count: '0};
                            end else begin
                                // fetch the next head into the cache
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = f_phys(r_head, COUNT_BITS'(1));
                                n_state       = S_POP_RD;
                            end
                        end
                    end
                end
            end
            S_POP_RD: begin
                n_cache  = i_rd_data;
                o_done   = 1'b1;
                o_result = '{head_valid: 1'b1, head: r_item, status: ST_DONE,
                             entry_count: r_count};
                n_state  = S_IDLE;
            end
            S_INS_CMP: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = f_phys(r_head, r_pos);
                if (i_rd_data.deadline > r_item.deadline) begin
                    // move the later entry up one slot and keep walking
                    o_mem.wr_data = i_rd_data;
                    n_pos         = r_pos - COUNT_BITS'(1);
                    if (r_pos == COUNT_BITS'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = f_phys(r_head, r_pos - COUNT_BITS'(2));
                    end
                end else begin
                    o_mem.wr_data = r_item;
                    n_count       = r_count + COUNT_BITS'(1);
                    o_done        = 1'b1;
                    o_result      = '{head_valid: 1'b1, head: r_cache, status: ST_DONE,
                                      entry_count: r_count + COUNT_BITS'(1)};
                    n_state       = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_head;
                o_mem.wr_data = r_item;
                n_cache       = r_item;
                n_count       = r_count + COUNT_BITS'(1);
                o_done        = 1'b1;
                o_result      = '{head_valid: 1'b1, head: r_item, status: ST_DONE,
                                  entry_count: r_count + COUNT_BITS'(1)};
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_item  <= n_item;
            r_cache <= n_cache;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> ((r_pos != '0) && (r_pos == r_count || r_pos < r_count)
                                    && (r_count != COUNT_BITS'(QUEUE_DEPTH))))
        else $error("insert walk position out of range");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.rd_en && o_mem.wr_en && (o_mem.rd_addr == o_mem.wr_addr)))
        else $error("read and write hit the same entry in one cycle");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_state != S_IDLE)) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after finishing");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for deadline_ordered_task_queue_unit: random insert/pop traffic
// against an in-bench sorted-queue predictor. Depends on dotq_pkg and the RTL only.
module tb_top;
    import dotq_pkg::*;

    localparam int TOTAL_REQUESTS = 1700;
    localparam int HOLD_OFF_START = 1000;
    localparam int HOLD_OFF_END   = 1400;
    localparam int RX_STEADY_FROM = 2000;
    localparam int RX_STEADY_TO   = 3000;
    localparam int TX_STEADY_FROM = 500;
    localparam int TX_STEADY_TO   = 800;
    localparam int IDLE_PCT       = 24;
    localparam int TAIL_CYCLES    = 40;

    typedef enum int {DL_TIES, DL_WIDE, DL_EDGES} t_dl_style;
    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    typedef struct {
        logic                     op;
        logic [DEADLINE_BITS-1:0] deadline;
        logic [PAYLOAD_BITS-1:0]  payload;
        bit                       wait_drain;
    } t_task_req;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_valid         = 1'b0;
    logic                     i_op            = OP_INSERT;
    logic [DEADLINE_BITS-1:0] i_task_deadline = '0;
    logic [PAYLOAD_BITS-1:0]  i_task_payload  = '0;
    logic                     i_stall         = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic                     o_head_valid;
    logic [DEADLINE_BITS-1:0] o_head_deadline;
    logic [PAYLOAD_BITS-1:0]  o_head_payload;
    logic [1:0]               o_status;
    logic [COUNT_BITS-1:0]    o_entry_count;

    t_task_req task_reqs[$];
    t_result   expected_heads[$];

    // Predictor state: sorted ready list, head at index 0.
    t_entry ready_list[QUEUE_DEPTH];
    int     ready_count = 0;

    int mismatch_count = 0;
    int offered_count  = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int insert_count   = 0;
    int pop_count      = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int deepest        = 0;

    deadline_ordered_task_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_task_deadline (i_task_deadline),
        .i_task_payload  (i_task_payload),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_head_valid    (o_head_valid),
        .o_head_deadline (o_head_deadline),
        .o_head_payload  (o_head_payload),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Apply one request to the ready list and return the result it must produce.
    function automatic t_result schedule_request(input logic op,
                                                 input logic [DEADLINE_BITS-1:0] dl,
                                                 input logic [PAYLOAD_BITS-1:0] pl);
        t_result r;
        int      pos;
        r = '0;
        if (op == OP_INSERT) begin
            insert_count++;
            if (ready_count >= QUEUE_DEPTH) begin
                full_refusals++;
                r.status = ST_FULL;
            end else begin
                // place after every task with a deadline less than or equal
                pos = 0;
                while (pos < ready_count && ready_list[pos].deadline <= dl) begin
                    pos++;
                end
                for (int i = ready_count; i > pos; i--) begin
                    ready_list[i] = ready_list[i-1];
                end
                ready_list[pos].deadline = dl;
                ready_list[pos].payload  = pl;
                ready_count++;
                r.status = ST_DONE;
            end
            if (ready_count > 0) begin
                r.head_valid = 1'b1;
                r.head       = ready_list[0];
            end
        end else begin
            pop_count++;
            if (ready_count == 0) begin
                empty_refusals++;
                r.status = ST_EMPTY;
            end else begin
                r.head_valid = 1'b1;
                r.head       = ready_list[0];
                for (int i = 1; i < ready_count; i++) begin
                    ready_list[i-1] = ready_list[i];
                end
                ready_count--;
                r.status = ST_DONE;
            end
        end
        if (ready_count > deepest) begin
            deepest = ready_count;
        end
        r.entry_count = COUNT_BITS'(ready_count);
        return r;
    endfunction

    function automatic logic [DEADLINE_BITS-1:0] pick_deadline(input t_dl_style style);
        case (style)
            DL_TIES: pick_deadline = DEADLINE_BITS'($urandom_range(0, 7));
            DL_EDGES: begin
                case ($urandom_range(0, 4))
                    0: pick_deadline = '0;
                    1: pick_deadline = '1;
                    2: pick_deadline = DEADLINE_BITS'(1);
                    3: pick_deadline = {1'b0, {(DEADLINE_BITS-1){1'b1}}};
                    default: pick_deadline = {1'b1, {(DEADLINE_BITS-1){1'b0}}};
                endcase
            end
            default: pick_deadline = DEADLINE_BITS'($urandom);
        endcase
    endfunction

    task automatic add_request(input logic op, input logic [DEADLINE_BITS-1:0] dl,
                               input logic [PAYLOAD_BITS-1:0] pl, input bit wait_drain);
        t_task_req req;
        req.op         = op;
        req.deadline   = dl;
        req.payload    = pl;
        req.wait_drain = wait_drain;
        task_reqs.push_back(req);
    endtask

    // Sender: offer requests, hold the payload while stalled, idle at random.
    always @(posedge i_clk) begin : sender
        t_task_req req;
        bit        idle;
        idle = !(offered_count >= TX_STEADY_FROM && offered_count < TX_STEADY_TO)
               && ($urandom_range(0, 99) < IDLE_PCT);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (task_reqs.size() != 0 && !idle
                && !(task_reqs[0].wait_drain && (i_valid || expected_heads.size() != 0))) begin
                req = task_reqs.pop_front();
                i_valid         <= 1'b1;
                i_op            <= req.op;
                i_task_deadline <= req.deadline;
                i_task_payload  <= req.payload;
                offered_count++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, one stretch without stalls.
    always @(posedge i_clk) begin : receiver
        int unsigned rx_cycle;
        if (!i_rst_n) begin
            rx_cycle = 0;
            i_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle >= HOLD_OFF_START && rx_cycle < HOLD_OFF_END) begin
                i_stall <= 1'b1;
            end else if (rx_cycle >= RX_STEADY_FROM && rx_cycle < RX_STEADY_TO) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Monitor: predict on each accepted request, then check each accepted result.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_heads.push_back(schedule_request(i_op, i_task_deadline,
                                                          i_task_payload));
                accepted_count++;
            end
            if (o_valid && !i_stall) begin
                if (expected_heads.size() == 0) begin
                    note_mismatch("result with no request outstanding");
                end else begin
                    want = expected_heads.pop_front();
                    checked_count++;
                    if (o_head_valid !== want.head_valid) begin
                        note_mismatch($sformatf("head_valid %0b, want %0b",
                                                o_head_valid, want.head_valid));
                    end
                    if (o_head_deadline !== want.head.deadline) begin
                        note_mismatch($sformatf("head_deadline %h, want %h",
                                                o_head_deadline, want.head.deadline));
                    end
                    if (o_head_payload !== want.head.payload) begin
                        note_mismatch($sformatf("head_payload %h, want %h",
                                                o_head_payload, want.head.payload));
                    end
                    if (o_status !== want.status) begin
                        note_mismatch($sformatf("status %0d, want %0d",
                                                o_status, want.status));
                    end
                    if (o_entry_count !== want.entry_count) begin
                        note_mismatch($sformatf("entry_count %0d, want %0d",
                                                o_entry_count, want.entry_count));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_phase    phase;
        t_dl_style style;
        int        len;
        int        ins_pct;
        bit        drain;
        logic      op;

        // Directed: pop while empty, extreme values, ties, fill to full, refused insert.
        add_request(OP_POP, '1, '1, 1'b0);
        add_request(OP_INSERT, '1, '1, 1'b0);
        add_request(OP_INSERT, '0, '0, 1'b0);
        add_request(OP_INSERT, '0, PAYLOAD_BITS'(1), 1'b0);
        add_request(OP_INSERT, {1'b1, {(DEADLINE_BITS-1){1'b0}}}, 32'h5555_5555, 1'b0);
        add_request(OP_INSERT, '1, 32'hAAAA_AAAA, 1'b0);
        // descending deadlines make each insert walk deep into the list
        for (int k = 0; k < 11; k++) begin
            add_request(OP_INSERT, DEADLINE_BITS'(32'h9000_0000 - k * 32'h0100_0000),
                        PAYLOAD_BITS'(k), 1'b0);
        end
        add_request(OP_INSERT, DEADLINE_BITS'(5), 32'hDEAD_BEEF, 1'b0);
        for (int k = 0; k < 5; k++) begin
            add_request(OP_POP, DEADLINE_BITS'($urandom), PAYLOAD_BITS'($urandom), 1'b0);
        end

        // Random phases biased toward filling, draining or mixing the queue.
        drain = 1'b1;
        while (task_reqs.size() < TOTAL_REQUESTS) begin
            phase = t_phase'($urandom_range(0, 2));
            style = t_dl_style'($urandom_range(0, 2));
            len   = $urandom_range(8, 28);
            case (phase)
                PH_FILL:  ins_pct = 85;
                PH_DRAIN: ins_pct = 15;
                default:  ins_pct = 50;
            endcase
            for (int k = 0; k < len; k++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
                add_request(op, pick_deadline(style), PAYLOAD_BITS'($urandom),
                            drain && k == 0);
            end
            drain = ($urandom_range(0, 7) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < offered_count || task_reqs.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_heads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_heads.size() != 0) begin
            note_mismatch("results still outstanding at end of run");
        end
        $display("Ran %0d requests (%0d inserts, %0d pops), %0d results checked.",
                 accepted_count, insert_count, pop_count, checked_count);
        $display("Inserts refused while full: %0d, pops refused while empty: %0d, depth %0d.",
                 full_refusals, empty_refusals, deepest);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
